[rtl/mrns_pkg.sv]
// ----------------------------------------------------------------------------
// mrns_pkg
// Shared types, codes and helpers for the memory region needle scanner.
// ----------------------------------------------------------------------------
package mrns_pkg;

  // Default number of needle slots in the comparator chain
  localparam int unsigned DEF_NEEDLE_SLOTS = 8;

  // Field widths
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned SLOT_IN_W  = 3;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned MTYPE_W    = 5;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned BUDGET_W   = 48;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned PAGE_SHIFT = 12;

  // Stream payload widths (whole bytes)
  localparam int unsigned IN_TDATA_W  = 200;
  localparam int unsigned OUT_TDATA_W = 136;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_START = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DESC  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DATA  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIN   = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_INCL_CONV = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEEDLE_CNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BUDGET = 2'd2;

  // Configuration reset values
  localparam logic [COUNT_W-1:0]  RST_NEEDLE_CNT = 4'd1;
  localparam logic [BUDGET_W-1:0] RST_BUDGET     = 48'd1073741824;

  // Memory type codes with special handling
  localparam logic [MTYPE_W-1:0] MT_LAST_PLAIN   = 5'd6;
  localparam logic [MTYPE_W-1:0] MT_CONVENTIONAL = 5'd7;
  localparam logic [MTYPE_W-1:0] MT_ACPI_RECLAIM = 5'd9;
  localparam logic [MTYPE_W-1:0] MT_ACPI_NVS     = 5'd10;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BUDGET    = 3'd2,
    ST_SKIPPED   = 3'd3,
    ST_ENDED     = 3'd4,
    ST_IGNORED   = 3'd5
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // Decide whether a descriptor type may be scanned
  function automatic logic type_readable(input logic [MTYPE_W-1:0] mtype,
                                         input logic incl_conv);
    logic ok;
    ok = (mtype <= MT_LAST_PLAIN) || (mtype == MT_ACPI_RECLAIM) ||
         (mtype == MT_ACPI_NVS) || ((mtype == MT_CONVENTIONAL) && incl_conv);
    return ok;
  endfunction

endpackage

[rtl/mrns_needle_cell.sv]
// ----------------------------------------------------------------------------
// mrns_needle_cell
// One needle slot of the comparator chain: holds a needle, compares the word
// passing by and hands word and first-hit information to the next slot.
// ----------------------------------------------------------------------------
module mrns_needle_cell #(
  parameter int unsigned INDEX  = 0,
  parameter int unsigned SLOT_W = 3
) (
  input  logic                             clk,
  input  logic                             load_en,
  input  logic [mrns_pkg::SLOT_IN_W-1:0]   load_slot,
  input  logic [mrns_pkg::WORD_W-1:0]      load_value,
  input  logic [mrns_pkg::COUNT_W-1:0]     needle_count,
  input  logic [mrns_pkg::WORD_W-1:0]      word_in,
  input  logic                             hit_in,
  input  logic [SLOT_W-1:0]                slot_in,
  output logic [mrns_pkg::WORD_W-1:0]      word_out,
  output logic                             hit_out,
  output logic [SLOT_W-1:0]                slot_out
);

  logic [mrns_pkg::WORD_W-1:0] needle_r;
  logic [mrns_pkg::WORD_W-1:0] word_r;
  logic                        hit_r;
  logic [SLOT_W-1:0]           slot_r;
  logic                        active;
  logic                        hit_nxt;
  logic [SLOT_W-1:0]           slot_nxt;

  // Slot takes part only below the configured count
  assign active = 32'(needle_count) > INDEX;

  // Keep an earlier hit, else report this slot on equality
  always_comb begin
    hit_nxt  = hit_in || (active && (needle_r == word_in));
    slot_nxt = hit_in ? slot_in : SLOT_W'(INDEX);
  end

  // Load the needle for this slot
  always_ff @(posedge clk) begin
    if (load_en && (32'(load_slot) == INDEX)) begin
      needle_r <= load_value;
    end
  end

  // Advance the word one slot per cycle
  always_ff @(posedge clk) begin
    word_r <= word_in;
    hit_r  <= hit_nxt;
    slot_r <= slot_nxt;
  end

  assign word_out = word_r;
  assign hit_out  = hit_r;
  assign slot_out = slot_r;

endmodule

[rtl/memory_region_needle_scanner.sv]
// ----------------------------------------------------------------------------
// memory_region_needle_scanner
// Command driven scanner that walks memory-map descriptors and looks for
// needle values in the data words of each accepted region.
// ----------------------------------------------------------------------------
// Every command gives exactly one result item. Commands other than a data
// word, and data words that arrive with no region open or after the walk has
// ended, post their result into the result register directly. A data word
// inside an open region travels down the chain of NEEDLE_SLOTS comparator
// slots, one slot per cycle, and no item is accepted until its result is
// posted. An item is accepted only while the block is idle and the result
// register is free or being drained. Needle slots hold no value after reset
// until loaded; no clearing pass is run.
module memory_region_needle_scanner #(
  parameter int unsigned NEEDLE_SLOTS = mrns_pkg::DEF_NEEDLE_SLOTS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [mrns_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mrns_pkg::BUDGET_W-1:0]        cfg_wdata,
  // Command input
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // slot[2:0], word_value[66:3], mem_type[71:67], region_base[135:72],
  // page_count[199:136]
  input  logic [mrns_pkg::IN_TDATA_W-1:0]      in_tdata,
  // command[2:0]
  input  logic [mrns_pkg::CMD_W-1:0]           in_tuser,
  // Result output
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // match[0], match_address[64:1], match_slot[67:65], bytes_scanned[131:68],
  // zero fill[135:132]
  output logic [mrns_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // status[2:0]
  output logic [mrns_pkg::STATUS_W-1:0]        out_tuser,
  // region_done
  output logic                                 out_tlast
);

  localparam int unsigned SLOT_W = (NEEDLE_SLOTS > 1) ? $clog2(NEEDLE_SLOTS) : 1;
  localparam int unsigned WW     = mrns_pkg::WORD_W;

  // Input fields
  logic [mrns_pkg::CMD_W-1:0]     in_cmd;
  logic [mrns_pkg::SLOT_IN_W-1:0] in_slot;
  logic [WW-1:0]                  in_word;
  logic [mrns_pkg::MTYPE_W-1:0]   in_mtype;
  logic [WW-1:0]                  in_base;
  logic [WW-1:0]                  in_pages;
  logic                           acc;

  assign in_cmd   = in_tuser;
  assign in_slot  = in_tdata[2:0];
  assign in_word  = in_tdata[66:3];
  assign in_mtype = in_tdata[71:67];
  assign in_base  = in_tdata[135:72];
  assign in_pages = in_tdata[199:136];

  // Configuration registers
  logic                              incl_conv_r;
  logic [mrns_pkg::COUNT_W-1:0]      needle_cnt_r;
  logic [mrns_pkg::BUDGET_W-1:0]     scan_budget_r;

  // Walk state
  mrns_pkg::state_t                  state_r, state_nxt;
  logic [SLOT_W-1:0]                 scan_cnt_r, scan_cnt_nxt;
  logic [WW-1:0]                     scan_offset_r, scan_offset_nxt;
  logic [WW-1:0]                     region_end_r, region_end_nxt;
  logic                              region_open_r, region_open_nxt;
  logic [WW-1:0]                     scanned_total_r, scanned_total_nxt;
  logic                              any_match_r, any_match_nxt;
  logic                              pass_halted_r, pass_halted_nxt;
  logic [WW-1:0]                     pend_addr_r, pend_addr_nxt;
  logic                              pend_done_r, pend_done_nxt;

  // Result register
  logic                              out_valid_r, out_valid_nxt;
  mrns_pkg::status_t                 out_status_r, out_status_nxt;
  logic                              out_match_r, out_match_nxt;
  logic [WW-1:0]                     out_addr_r, out_addr_nxt;
  logic [mrns_pkg::SLOT_IN_W-1:0]    out_slot_r, out_slot_nxt;
  logic                              out_done_r, out_done_nxt;
  logic [WW-1:0]                     out_bytes_r, out_bytes_nxt;

  // Descriptor arithmetic
  logic [WW-1:0]                     span;
  logic                              pages_big;
  logic [WW:0]                       end_sum;
  logic [WW:0]                       total_sum;
  logic                              budget_used;
  logic [WW-1:0]                     offset_step;
  logic                              load_en;

  // Comparator chain links
  logic [WW-1:0]                     link_word [NEEDLE_SLOTS+1];
  logic                              link_hit  [NEEDLE_SLOTS+1];
  logic [SLOT_W-1:0]                 link_slot [NEEDLE_SLOTS+1];
  logic [WW-1:0]                     last_slot_ext;

  assign in_tready = (state_r == mrns_pkg::S_IDLE) && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  assign load_en   = acc && (in_cmd == mrns_pkg::CMD_LOAD);

  assign span        = {in_pages[WW-mrns_pkg::PAGE_SHIFT-1:0], {mrns_pkg::PAGE_SHIFT{1'b0}}};
  assign pages_big   = |in_pages[WW-1:WW-mrns_pkg::PAGE_SHIFT];
  assign end_sum     = {1'b0, in_base} + {1'b0, span};
  assign total_sum   = {1'b0, scanned_total_r} + {1'b0, span};
  assign budget_used = scanned_total_r >= {{(WW-mrns_pkg::BUDGET_W){1'b0}}, scan_budget_r};
  assign offset_step = scan_offset_r + WW'(8);

  // Feed the chain head
  assign link_word[0] = in_word;
  assign link_hit[0]  = 1'b0;
  assign link_slot[0] = '0;

  // Build the comparator chain
  for (genvar g = 0; g < NEEDLE_SLOTS; g++) begin : g_slot
    mrns_needle_cell #(
      .INDEX  (g),
      .SLOT_W (SLOT_W)
    ) u_slot (
      .clk          (clk),
      .load_en      (load_en),
      .load_slot    (in_slot),
      .load_value   (in_word),
      .needle_count (needle_cnt_r),
      .word_in      (link_word[g]),
      .hit_in       (link_hit[g]),
      .slot_in      (link_slot[g]),
      .word_out     (link_word[g+1]),
      .hit_out      (link_hit[g+1]),
      .slot_out     (link_slot[g+1])
    );
  end

  assign last_slot_ext = WW'(link_slot[NEEDLE_SLOTS]);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      incl_conv_r   <= 1'b0;
      needle_cnt_r  <= mrns_pkg::RST_NEEDLE_CNT;
      scan_budget_r <= mrns_pkg::RST_BUDGET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mrns_pkg::CFG_INCL_CONV:  incl_conv_r   <= cfg_wdata[0];
        mrns_pkg::CFG_NEEDLE_CNT: needle_cnt_r  <= cfg_wdata[mrns_pkg::COUNT_W-1:0];
        mrns_pkg::CFG_BUDGET:     scan_budget_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state and result
  always_comb begin
    state_nxt         = state_r;
    scan_cnt_nxt      = scan_cnt_r;
    scan_offset_nxt   = scan_offset_r;
    region_end_nxt    = region_end_r;
    region_open_nxt   = region_open_r;
    scanned_total_nxt = scanned_total_r;
    any_match_nxt     = any_match_r;
    pass_halted_nxt   = pass_halted_r;
    pend_addr_nxt     = pend_addr_r;
    pend_done_nxt     = pend_done_r;
    out_valid_nxt     = out_valid_r && !out_tready;
    out_status_nxt    = out_status_r;
    out_match_nxt     = out_match_r;
    out_addr_nxt      = out_addr_r;
    out_slot_nxt      = out_slot_r;
    out_done_nxt      = out_done_r;
    out_bytes_nxt     = out_bytes_r;

    unique case (state_r)
      mrns_pkg::S_IDLE: begin
        if (acc) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = mrns_pkg::ST_IGNORED;
          out_match_nxt  = 1'b0;
          out_addr_nxt   = '0;
          out_slot_nxt   = '0;
          out_done_nxt   = 1'b0;
          unique case (in_cmd)
            mrns_pkg::CMD_START: begin
              scan_offset_nxt   = '0;
              region_end_nxt    = '0;
              region_open_nxt   = 1'b0;
              scanned_total_nxt = '0;
              any_match_nxt     = 1'b0;
              pass_halted_nxt   = 1'b0;
              out_status_nxt    = mrns_pkg::ST_OK;
            end
            mrns_pkg::CMD_LOAD: begin
              if (32'(in_slot) < NEEDLE_SLOTS) begin
                out_status_nxt = mrns_pkg::ST_OK;
              end
            end
            mrns_pkg::CMD_DESC: begin
              priority if (pass_halted_r) begin
                out_status_nxt = mrns_pkg::ST_ENDED;
              end else if (budget_used) begin
                out_status_nxt = mrns_pkg::ST_BUDGET;
              end else if (!mrns_pkg::type_readable(in_mtype, incl_conv_r) ||
                           pages_big || end_sum[WW]) begin
                out_status_nxt = mrns_pkg::ST_SKIPPED;
              end else begin
                scanned_total_nxt = total_sum[WW] ? '1 : total_sum[WW-1:0];
                region_open_nxt   = |in_pages;
                scan_offset_nxt   = in_base;
                region_end_nxt    = end_sum[WW-1:0];
                out_status_nxt    = mrns_pkg::ST_OK;
              end
            end
            mrns_pkg::CMD_DATA: begin
              if (pass_halted_r) begin
                out_status_nxt = mrns_pkg::ST_ENDED;
              end else if (region_open_r) begin
                // Send the word down the chain; result comes out at its end
                out_valid_nxt = 1'b0;
                pend_addr_nxt = scan_offset_r;
                pend_done_nxt = (offset_step == region_end_r);
                if (offset_step == region_end_r) begin
                  region_open_nxt = 1'b0;
                end else begin
                  scan_offset_nxt = offset_step;
                end
                scan_cnt_nxt = '0;
                state_nxt    = mrns_pkg::S_SCAN;
              end
            end
            mrns_pkg::CMD_STOP: begin
              pass_halted_nxt = 1'b1;
              region_open_nxt = 1'b0;
              out_status_nxt  = mrns_pkg::ST_OK;
            end
            mrns_pkg::CMD_FIN: begin
              pass_halted_nxt = 1'b1;
              region_open_nxt = 1'b0;
              priority if (budget_used) begin
                out_status_nxt = mrns_pkg::ST_BUDGET;
              end else if (any_match_r) begin
                out_status_nxt = mrns_pkg::ST_OK;
              end else begin
                out_status_nxt = mrns_pkg::ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
          out_bytes_nxt = scanned_total_nxt;
        end
      end
      mrns_pkg::S_SCAN: begin
        if (scan_cnt_r == SLOT_W'(NEEDLE_SLOTS - 1)) begin
          // Chain end reached: post the word's result
          out_valid_nxt  = 1'b1;
          out_status_nxt = mrns_pkg::ST_OK;
          out_match_nxt  = link_hit[NEEDLE_SLOTS];
          out_addr_nxt   = link_hit[NEEDLE_SLOTS] ? pend_addr_r : '0;
          out_slot_nxt   = link_hit[NEEDLE_SLOTS] ?
                           last_slot_ext[mrns_pkg::SLOT_IN_W-1:0] : '0;
          out_done_nxt   = pend_done_r;
          out_bytes_nxt  = scanned_total_r;
          any_match_nxt  = any_match_r || link_hit[NEEDLE_SLOTS];
          state_nxt      = mrns_pkg::S_IDLE;
        end else begin
          scan_cnt_nxt = scan_cnt_r + SLOT_W'(1);
        end
      end
      default: state_nxt = mrns_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= mrns_pkg::S_IDLE;
      scan_cnt_r      <= '0;
      scan_offset_r   <= '0;
      region_end_r    <= '0;
      region_open_r   <= 1'b0;
      scanned_total_r <= '0;
      any_match_r     <= 1'b0;
      pass_halted_r   <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      scan_cnt_r      <= scan_cnt_nxt;
      scan_offset_r   <= scan_offset_nxt;
      region_end_r    <= region_end_nxt;
      region_open_r   <= region_open_nxt;
      scanned_total_r <= scanned_total_nxt;
      any_match_r     <= any_match_nxt;
      pass_halted_r   <= pass_halted_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_addr_r  <= pend_addr_nxt;
    pend_done_r  <= pend_done_nxt;
    out_status_r <= out_status_nxt;
    out_match_r  <= out_match_nxt;
    out_addr_r   <= out_addr_nxt;
    out_slot_r   <= out_slot_nxt;
    out_done_r   <= out_done_nxt;
    out_bytes_r  <= out_bytes_nxt;
  end

  // Drive the result channel
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_done_r;
  assign out_tdata  = {4'b0000, out_bytes_r, out_slot_r, out_addr_r, out_match_r};

  // A word inside an open region always enters the chain
  a_data_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_cmd == mrns_pkg::CMD_DATA) && region_open_r && !pass_halted_r)
      |=> (state_r == mrns_pkg::S_SCAN))
    else $error("open-region data word did not enter the comparator chain");

  // No result is pending while a word is in the chain
  a_scan_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrns_pkg::S_SCAN) |-> !out_valid_r)
    else $error("result register busy during chain scan");

  // Open region always has at least one word left
  a_region_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    region_open_r |-> (scan_offset_r != region_end_r))
    else $error("open region has no words left");

  // Ended walk never keeps a region open
  a_halt_closes: assert property (@(posedge clk) disable iff (!rst_n)
    pass_halted_r |-> !region_open_r)
    else $error("region open after walk ended");

  // Matches are reported only with an ok status
  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_match_r) |-> (out_status_r == mrns_pkg::ST_OK))
    else $error("match reported with non-ok status");

endmodule

[dv/mrns_scan_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrns_scan_checker
// Watches the register, command and result ports of the needle scanner. Each
// accepted command is run through a local copy of the scanner state to build
// the result it must produce; each accepted result is compared field by field
// with the oldest result still awaited.
// ----------------------------------------------------------------------------
module mrns_scan_checker #(
  parameter int unsigned NEEDLE_SLOTS = mrns_pkg::DEF_NEEDLE_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mrns_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mrns_pkg::BUDGET_W-1:0]    cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // slot, word_value, mem_type, region_base, page_count
  input  logic [mrns_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic [mrns_pkg::CMD_W-1:0]       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // match, match_address, match_slot, bytes_scanned, zero fill
  input  logic [mrns_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  input  logic [mrns_pkg::STATUS_W-1:0]    out_tuser,
  input  logic                             out_tlast,
  output int unsigned                      mismatches,
  output int unsigned                      reports_due
);
  import mrns_pkg::*;

  localparam int unsigned IDX_W = (NEEDLE_SLOTS > 1) ? $clog2(NEEDLE_SLOTS) : 1;

  typedef struct packed {
    status_t     status;
    logic        hit;
    logic [63:0] hit_addr;
    logic [2:0]  hit_slot;
    logic        last_word;
    logic [63:0] total;
  } scan_report_t;

  scan_report_t awaited_reports[$];
  int unsigned  fault_count = 0;

  // Local copy of the scanner registers and state
  logic                conv_readable;
  logic [COUNT_W-1:0]  active_slots;
  logic [BUDGET_W-1:0] byte_budget;
  logic [WORD_W-1:0]   needle_mem [NEEDLE_SLOTS];
  logic [63:0]         walk_addr;
  logic [63:0]         walk_last;
  logic [63:0]         bytes_total;
  logic                walk_open;
  logic                saw_hit;
  logic                walk_halted;

  // Memory types that a descriptor may carry and still be walked
  function automatic logic kind_scannable(input logic [MTYPE_W-1:0] kind);
    case (kind)
      MT_CONVENTIONAL:             return conv_readable;
      MT_ACPI_RECLAIM, MT_ACPI_NVS: return 1'b1;
      default:                     return kind <= MT_LAST_PLAIN;
    endcase
  endfunction

  // Advance the local state by one command and queue the result it gives
  task automatic apply_command(input logic [CMD_W-1:0] cmd,
                               input logic [IN_TDATA_W-1:0] payload);
    logic [2:0]         slot;
    logic [63:0]        word;
    logic [MTYPE_W-1:0] kind;
    logic [63:0]        base;
    logic [63:0]        pages;
    logic [63:0]        span;
    int unsigned        width;
    scan_report_t       rep;
    slot  = payload[2:0];
    word  = payload[66:3];
    kind  = payload[71:67];
    base  = payload[135:72];
    pages = payload[199:136];
    span  = {pages[51:0], 12'h000};
    rep = '0;
    rep.status = ST_IGNORED;
    case (cmd)
      CMD_START: begin
        walk_addr   = '0;
        walk_last   = '0;
        walk_open   = 1'b0;
        bytes_total = '0;
        saw_hit     = 1'b0;
        walk_halted = 1'b0;
        rep.status  = ST_OK;
      end
      CMD_LOAD: begin
        if (slot < NEEDLE_SLOTS) begin
          needle_mem[IDX_W'(slot)] = word;
          rep.status = ST_OK;
        end
      end
      CMD_DESC: begin
        if (walk_halted) begin
          rep.status = ST_ENDED;
        end else if (bytes_total >= byte_budget) begin
          rep.status = ST_BUDGET;
        end else if (!kind_scannable(kind) || pages[63:52] != '0 || base > ~span) begin
          rep.status = ST_SKIPPED;
        end else begin
          // Saturate the total; a span under one word opens nothing
          bytes_total = (bytes_total > ~span) ? '1 : bytes_total + span;
          walk_open = 1'b0;
          if (span >= 64'd8) begin
            walk_open = 1'b1;
            walk_addr = base;
            walk_last = base + span - 64'd8;
          end
          rep.status = ST_OK;
        end
      end
      CMD_DATA: begin
        if (walk_halted) begin
          rep.status = ST_ENDED;
        end else if (walk_open) begin
          width = (active_slots > NEEDLE_SLOTS) ? NEEDLE_SLOTS : active_slots;
          // Lowest matching slot wins
          for (int unsigned i = 0; i < width; i++) begin
            if (!rep.hit && needle_mem[IDX_W'(i)] == word) begin
              rep.hit      = 1'b1;
              rep.hit_addr = walk_addr;
              rep.hit_slot = 3'(i);
              saw_hit      = 1'b1;
            end
          end
          if (walk_addr == walk_last) begin
            rep.last_word = 1'b1;
            walk_open     = 1'b0;
          end else begin
            walk_addr = walk_addr + 64'd8;
          end
          rep.status = ST_OK;
        end
      end
      CMD_STOP: begin
        walk_halted = 1'b1;
        walk_open   = 1'b0;
        rep.status  = ST_OK;
      end
      CMD_FIN: begin
        walk_halted = 1'b1;
        walk_open   = 1'b0;
        if (bytes_total >= byte_budget) rep.status = ST_BUDGET;
        else if (saw_hit) rep.status = ST_OK;
        else rep.status = ST_NOT_FOUND;
      end
      default: begin
      end
    endcase
    rep.total = bytes_total;
    awaited_reports.push_back(rep);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fault_count++;
    end
  endtask

  // Match one accepted result against the oldest awaited one
  task automatic check_result();
    scan_report_t want;
    if (awaited_reports.size() == 0) begin
      $error("result item with no command outstanding, status %0d", out_tuser);
      fault_count++;
    end else begin
      want = awaited_reports.pop_front();
      compare_field("status", 64'(want.status), 64'(out_tuser));
      compare_field("match", 64'(want.hit), 64'(out_tdata[0]));
      compare_field("match_address", want.hit_addr, out_tdata[64:1]);
      compare_field("match_slot", 64'(want.hit_slot), 64'(out_tdata[67:65]));
      compare_field("region_done", 64'(want.last_word), 64'(out_tlast));
      compare_field("bytes_scanned", want.total, out_tdata[131:68]);
    end
  endtask

  // Sample every port at the clock edge, in register, command, result order
  always @(posedge clk) begin
    if (!rst_n) begin
      conv_readable = 1'b0;
      active_slots  = RST_NEEDLE_CNT;
      byte_budget   = RST_BUDGET;
      walk_addr     = '0;
      walk_last     = '0;
      walk_open     = 1'b0;
      bytes_total   = '0;
      saw_hit       = 1'b0;
      walk_halted   = 1'b0;
      awaited_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_INCL_CONV:  conv_readable = cfg_wdata[0];
          CFG_NEEDLE_CNT: active_slots  = cfg_wdata[COUNT_W-1:0];
          CFG_BUDGET:     byte_budget   = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) apply_command(in_tuser, in_tdata);
      if (out_tvalid && out_tready) check_result();
    end
    reports_due <= awaited_reports.size();
    mismatches  <= fault_count;
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the memory region needle scanner. A short directed sequence
// covers the edge cases of descriptors, matches and pass endings; random
// passes follow under several register settings, one of them walking a whole
// page region to its last word. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import mrns_pkg::*;

  localparam int unsigned SLOTS     = DEF_NEEDLE_SLOTS;
  localparam int unsigned ITEM_GOAL = 1300;
  // Command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [BUDGET_W-1:0]    cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tlast;
  int unsigned            checker_faults;
  int unsigned            reports_due;

  // Stimulus bookkeeping
  logic [63:0] needle_vals [SLOTS];
  int unsigned commands_sent = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  memory_region_needle_scanner #(.NEEDLE_SLOTS(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  mrns_scan_checker #(.NEEDLE_SLOTS(SLOTS)) scan_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (checker_faults),
    .reports_due (reports_due)
  );

  always #10 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #6_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [63:0] noise64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [MTYPE_W-1:0] pick_kind();
    case ($urandom_range(0, 15))
      9:       return MT_ACPI_RECLAIM;
      10:      return MT_ACPI_NVS;
      11, 12:  return MT_CONVENTIONAL;
      13, 14, 15: return MTYPE_W'($urandom_range(MT_CONVENTIONAL + 1, 31));
      default: return MTYPE_W'($urandom_range(0, MT_LAST_PLAIN));
    endcase
  endfunction

  // Present one item after a random gap and hold it until accepted
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [2:0] slot,
                              input logic [63:0] word, input logic [MTYPE_W-1:0] kind,
                              input logic [63:0] base, input logic [63:0] pages);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {pages, base, kind, word, slot};
    do @(posedge clk); while (!in_tready);
    if (cmd <= CMD_FIN) commands_sent++;
  endtask

  // Commands whose payload is don't-care carry random bits
  task automatic send_bare(input logic [CMD_W-1:0] cmd);
    send_command(cmd, 3'($urandom), noise64(), MTYPE_W'($urandom), noise64(), noise64());
  endtask

  task automatic send_word(input logic [63:0] word);
    send_command(CMD_DATA, 3'($urandom), word, MTYPE_W'($urandom), noise64(), noise64());
  endtask

  task automatic load_needle(input logic [2:0] slot, input logic [63:0] value);
    needle_vals[slot] = value;
    send_command(CMD_LOAD, slot, value, MTYPE_W'($urandom), noise64(), noise64());
  endtask

  task automatic offer_region(input logic [MTYPE_W-1:0] kind, input logic [63:0] base,
                              input logic [63:0] pages);
    send_command(CMD_DESC, 3'($urandom), noise64(), kind, base, pages);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
  endtask

  task automatic set_registers(input logic conv, input logic [COUNT_W-1:0] count,
                               input logic [BUDGET_W-1:0] budget);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_INCL_CONV;
    cfg_wdata <= BUDGET_W'(conv);
    @(posedge clk);
    cfg_addr  <= CFG_NEEDLE_CNT;
    cfg_wdata <= BUDGET_W'(count);
    @(posedge clk);
    cfg_addr  <= CFG_BUDGET;
    cfg_wdata <= budget;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Data words hit a loaded needle about four times in ten
  task automatic feed_words(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) drain_results();
      if ($urandom_range(0, 9) < 4) send_word(needle_vals[3'($urandom_range(0, SLOTS - 1))]);
      else send_word(noise64());
    end
  endtask

  // Mostly small valid descriptors, some oversized, wrapping or empty
  task automatic offer_random_region();
    logic [63:0] pages;
    logic [63:0] span;
    logic [63:0] base;
    case ($urandom_range(0, 19))
      0:       pages = '0;
      1:       pages = noise64() | 64'h0010_0000_0000_0000;
      2:       pages = noise64() & 64'h000F_FFFF_FFFF_FFFF;
      default: pages = 64'($urandom_range(1, 4));
    endcase
    span = {pages[51:0], 12'h000};
    base = noise64();
    case ($urandom_range(0, 9))
      0: if (span != '0) base = ~span + 64'($urandom_range(1, 4095));
      1: base = ~span;
      default: base = base & ~span;
    endcase
    offer_region(pick_kind(), base, pages);
  endtask

  task automatic random_pass(input bit full_walk);
    logic [2:0] slot;
    if (full_walk || $urandom_range(0, 9) != 0) send_bare(CMD_START);
    else send_bare($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI);
    repeat ($urandom_range(0, 2)) begin
      slot = 3'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        load_needle(slot, needle_vals[3'($urandom_range(0, SLOTS - 1))]);
      end else begin
        load_needle(slot, noise64());
      end
    end
    // One page region walked past its last word
    if (full_walk) begin
      offer_region(MTYPE_W'($urandom_range(0, MT_LAST_PLAIN)),
                   noise64() & 64'hFFFF_FFFF_FFFF_EFFF, 64'd1);
      feed_words(515);
    end
    repeat ($urandom_range(1, 4)) begin
      offer_random_region();
      feed_words($urandom_range(0, 14));
      if ($urandom_range(0, 19) == 0) send_bare(CMD_SPARE_HI);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_bare(CMD_FIN);
      4, 5: begin
        send_bare(CMD_STOP);
        send_bare(CMD_FIN);
      end
      6, 7: send_bare(CMD_STOP);
      8: begin
        send_bare(CMD_FIN);
        feed_words(1);
        offer_random_region();
      end
      default: begin
      end
    endcase
  endtask

  task automatic run_directed();
    set_registers(1'b0, 4'd8, '1);
    // Needles: zero, all ones, and a value shared by slots 3 and 5
    load_needle(3'd0, 64'h0);
    load_needle(3'd1, '1);
    load_needle(3'd2, 64'h0123_4567_89AB_CDEF);
    load_needle(3'd3, 64'hA5A5_5A5A_A5A5_5A5A);
    load_needle(3'd4, noise64());
    load_needle(3'd5, 64'hA5A5_5A5A_A5A5_5A5A);
    load_needle(3'd6, noise64());
    load_needle(3'd7, noise64());
    // Word before any region, then an undefined command
    send_word(64'h0);
    send_bare(CMD_SPARE_HI);
    send_bare(CMD_START);
    // Reserved type, conventional while disabled, too many pages, wrap
    offer_region(MT_CONVENTIONAL + 5'd1, 64'h1000, 64'd1);
    offer_region(MT_CONVENTIONAL, 64'h1000, 64'd1);
    offer_region(MT_LAST_PLAIN, 64'h0, 64'h0010_0000_0000_0000);
    offer_region(MT_ACPI_RECLAIM, 64'hFFFF_FFFF_FFFF_F000, 64'd1);
    // Zero span is counted but opens nothing
    offer_region(5'd0, 64'h2000, 64'd0);
    send_word(64'h0);
    // Region whose end address is the top byte of the address space
    offer_region(MT_ACPI_NVS, 64'hFFFF_FFFF_FFFF_EFFF, 64'd1);
    send_word('1);
    send_word(64'hA5A5_5A5A_A5A5_5A5A);
    // Abandon the open region, then saturate the byte total
    offer_region(5'd0, 64'h0, 64'd2);
    offer_region(5'd3, 64'h5, 64'h000F_FFFF_FFFF_FFFF);
    offer_region(5'd1, 64'h0, 64'd1);
    send_bare(CMD_FIN);
    offer_region(5'd2, 64'h4000, 64'd1);
    send_word('1);
  endtask

  // Receiver: random stall before each result, none in calm phases
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_end;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    phase = 0;
    while (commands_sent < ITEM_GOAL) begin
      case (phase)
        0: set_registers(1'b1, 4'd15, '1);
        1: set_registers(1'b0, 4'd0, '0);
        2: set_registers(1'b1, 4'd1, BUDGET_W'($urandom_range(4096, 60000)));
        default: begin
          case ($urandom_range(0, 3))
            0:       set_registers(1'($urandom), 4'($urandom), '0);
            1:       set_registers(1'($urandom), 4'($urandom_range(1, 8)), '1);
            2:       set_registers(1'($urandom), 4'($urandom_range(1, 8)),
                                   BUDGET_W'(noise64()));
            default: set_registers(1'($urandom), 4'($urandom_range(1, 8)),
                                   BUDGET_W'($urandom_range(4096, 60000)));
          endcase
        end
      endcase
      tx_calm = (phase % 3 == 2);
      rx_calm = (phase % 4 == 3);
      phase_end = commands_sent + 150;
      if (phase == 0) random_pass(1'b1);
      while (commands_sent < phase_end && commands_sent < ITEM_GOAL) random_pass(1'b0);
      phase++;
    end
    drain_results();
    repeat (3 * SLOTS) @(posedge clk);
    if (checker_faults == 0 && reports_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
